FILE: rtl/can_multiframe_transfer_framer_unit_macros.svh
// Assertion macros for the CAN multi-frame transfer framer.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CAN_MULTIFRAME_TRANSFER_FRAMER_UNIT_MACROS_SVH
`define CAN_MULTIFRAME_TRANSFER_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define CMF_CHECK(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication, masked while reset is high
`define CMF_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

FILE: rtl/cmf_pkg.sv
// Shared types, constants and the CRC step for the CAN multi-frame framer.
// No dependencies; used by the channel interfaces and the top level.
package cmf_pkg;

   typedef enum logic [0:0] {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   localparam int          FIRST_DATA     = 5;
   localparam int          FRAME_DATA_MAX = 7;
   localparam logic [7:0]  PERIOD_RESET   = 8'd25;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;

   // CRC-16-CCITT over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {d, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/cmf_channels.sv
// Valid/ready channel interfaces for the framer's request and response sides.
// Depends on cmf_pkg for the command type.
interface cmf_req_if import cmf_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     command;
   logic [5:0]  byte_index;
   logic [7:0]  byte_value;
   logic        mailbox_free;

   modport source (output valid, command, byte_index, byte_value, mailbox_free,
                   input ready);
   modport sink   (input valid, command, byte_index, byte_value, mailbox_free,
                   output ready);
endinterface

interface cmf_rsp_if import cmf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [63:0] frame_data;
   logic [3:0]  frame_length;
   logic [3:0]  frame_number;
   logic        frame_accepted;
   logic        transfer_done;

   modport source (output valid, frame_data, frame_length, frame_number, frame_accepted,
                   transfer_done, input ready);
   modport sink   (input valid, frame_data, frame_length, frame_number, frame_accepted,
                   transfer_done, output ready);
endinterface

FILE: rtl/can_multiframe_transfer_framer_unit.sv
// CAN multi-frame transfer framer: staging/transmit payload memories, byte-serial
// CRC-16-CCITT, byte-serial frame assembly. Depends on cmf_pkg, cmf_channels, macros.
//
//   channel   direction  transfer carries
//   req       in         command, byte_index, byte_value, mailbox_free
//   rsp       out        frame_data, frame_length, frame_number, frame_accepted,
//                        transfer_done
//   csr       in         period_ticks (write only, csr_wr_en / csr_wr_data)
//
// A byte write or a tick that emits nothing leaves the block idle; writes stream at one per
// cycle while it is idle. A tick that emits a frame primes the transmit read port, shifts 8
// byte slots through the frame register, then hands over the result.
// A tick that starts a transfer first copies staging to transmit memory, one byte a cycle
// through the staging read port, feeding the CRC.
// Reset is synchronous; staging entries carry valid bits, so there is no clearing pass.
// A stalled rsp holds the block in its hand-over state; req.ready stays low until it drains.
`include "can_multiframe_transfer_framer_unit_macros.svh"

module can_multiframe_transfer_framer_unit import cmf_pkg::*; #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   cmf_req_if.sink    req,
   cmf_rsp_if.source  rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int AW          = $clog2(PAYLOAD_BYTES);
   localparam int PW          = $clog2(PAYLOAD_BYTES + 1);
   localparam int FRAME_TOTAL = 1 + (PAYLOAD_BYTES - FIRST_DATA + FRAME_DATA_MAX - 1)
                                    / FRAME_DATA_MAX;
   localparam int FW          = $clog2(FRAME_TOTAL);

   localparam logic [PW-1:0] P_W        = PW'(PAYLOAD_BYTES);
   localparam logic [7:0]    P_8        = 8'(PAYLOAD_BYTES);
   localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_TOTAL - 1);
   localparam logic [PW-1:0] DATA_MAX_W = PW'(FRAME_DATA_MAX);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_FRAME,
      S_EMIT
   } state_type;

   state_type         state_ff;

   // Control and transfer state
   logic [7:0]        period_ff;
   logic [7:0]        tick_ff;
   logic              xfer_active_ff;
   logic [4:0]        xfer_cnt_ff;
   logic [FW-1:0]     frame_ff;
   logic [PW-1:0]     frame_base_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [PW-1:0]     cp_cnt_ff;
   logic [2:0]        slot_ff;
   logic              mbox_ff;
   logic [15:0]       crc_ff;
   logic [63:0]       data_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [63:0]       rsp_data_ff;
   logic [3:0]        rsp_len_ff;
   logic [3:0]        rsp_num_ff;
   logic              rsp_acc_ff;
   logic              rsp_done_ff;

   // Payload memories
   logic [7:0]              stg_mem [PAYLOAD_BYTES];
   logic [7:0]              tx_mem  [PAYLOAD_BYTES];
   logic [PAYLOAD_BYTES-1:0] stg_valid_ff;
   logic [7:0]              stg_q_ff;
   logic                    stg_v_ff;
   logic [7:0]              tx_q_ff;

   logic              req_acc;
   logic              tick_acc;
   logic              stg_wr;
   logic [7:0]        tick_in;
   logic              period_hit;
   logic              cp_last;
   logic [7:0]        copy_byte;
   logic [AW-1:0]     cp_wa;
   logic [PW-1:0]     remaining;
   logic [2:0]        n_data;
   logic [7:0]        tail;
   logic              consume;
   logic [7:0]        slot_byte;
   logic [3:0]        frame_len;
   logic              out_free;
   logic              is_last;

   assign req.ready  = (state_ff == S_IDLE);
   assign req_acc    = req.valid && req.ready;
   assign tick_acc   = req_acc && (req.command == CMD_TICK);
   assign stg_wr     = req_acc && (req.command == CMD_WRITE) && ({2'b00, req.byte_index} < P_8);

   assign tick_in    = tick_ff + 8'd1;
   assign period_hit = (tick_in >= period_ff);

   assign cp_last    = (cp_cnt_ff == P_W);
   assign cp_wa      = AW'(cp_cnt_ff - PW'(1));
   assign copy_byte  = stg_v_ff ? stg_q_ff : 8'h00;

   // Payload bytes left from this frame's base, capped at a full frame
   assign remaining  = P_W - frame_base_ff;
   assign n_data     = (remaining > DATA_MAX_W) ? 3'd7 : remaining[2:0];
   assign is_last    = (frame_ff == LAST_FRAME);
   assign tail       = {(frame_ff == '0), is_last, frame_ff[0], xfer_cnt_ff};
   assign frame_len  = (frame_ff == '0) ? 4'd8 : ({1'b0, n_data} + 4'd1);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // Pick the byte for the current slot; payload slots take the transmit read port
   always_comb begin
      consume   = 1'b0;
      slot_byte = 8'h00;
      if (frame_ff == '0) begin
         case (slot_ff)
            3'd0:    slot_byte = crc_ff[7:0];
            3'd1:    slot_byte = crc_ff[15:8];
            3'd7:    slot_byte = tail;
            default: begin
               slot_byte = tx_q_ff;
               consume   = 1'b1;
            end
         endcase
      end else if (slot_ff < n_data) begin
         slot_byte = tx_q_ff;
         consume   = 1'b1;
      end else if (slot_ff == n_data) begin
         slot_byte = tail;
      end
   end

   // Read pointer: reload from frame base on a tick, zero at copy end, advance per payload byte
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      case (state_ff)
         S_IDLE: begin
            if (tick_acc) begin
               rd_ptr_in = frame_base_ff;
            end
         end
         S_COPY: begin
            if (cp_last) begin
               rd_ptr_in = '0;
            end
         end
         S_FRAME: begin
            if (consume) begin
               rd_ptr_in = rd_ptr_ff + PW'(1);
            end
         end
         default: rd_ptr_in = rd_ptr_ff;
      endcase
   end

   // Staging memory: written by byte writes, swept by the copy
   always_ff @(posedge clock) begin
      if (stg_wr) begin
         stg_mem[AW'(req.byte_index)] <= req.byte_value;
      end
      stg_q_ff <= stg_mem[cp_cnt_ff[AW-1:0]];
      stg_v_ff <= stg_valid_ff[cp_cnt_ff[AW-1:0]];
   end

   // Staging valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else if (stg_wr) begin
         stg_valid_ff[AW'(req.byte_index)] <= 1'b1;
      end
   end

   // Transmit memory: filled by the copy, read a byte at a time for the frames
   always_ff @(posedge clock) begin
      if (state_ff == S_COPY && cp_cnt_ff != '0) begin
         tx_mem[cp_wa] <= copy_byte;
      end
      tx_q_ff <= tx_mem[rd_ptr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         period_ff      <= PERIOD_RESET;
         tick_ff        <= PERIOD_RESET - 8'd1;
         xfer_active_ff <= 1'b0;
         xfer_cnt_ff    <= '0;
         frame_ff       <= '0;
         frame_base_ff  <= '0;
         rd_ptr_ff      <= '0;
         cp_cnt_ff      <= '0;
         slot_ff        <= '0;
         mbox_ff        <= 1'b0;
         crc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         // drop the result once the sink takes it
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (tick_acc) begin
                  mbox_ff <= req.mailbox_free;
                  slot_ff <= '0;
                  if (period_hit) begin
                     tick_ff <= '0;
                  end else begin
                     tick_ff <= tick_in;
                  end
                  if (period_hit && !xfer_active_ff) begin
                     // snapshot the staging payload and restart the CRC
                     xfer_active_ff <= 1'b1;
                     frame_ff       <= '0;
                     frame_base_ff  <= '0;
                     cp_cnt_ff      <= '0;
                     crc_ff         <= CRC_INIT;
                     state_ff       <= S_COPY;
                  end else if (xfer_active_ff) begin
                     state_ff <= S_FRAME;
                  end
               end
            end
            S_COPY: begin
               cp_cnt_ff <= cp_cnt_ff + PW'(1);
               if (cp_cnt_ff != '0) begin
                  crc_ff <= crc_byte(crc_ff, copy_byte);
               end
               if (cp_last) begin
                  slot_ff  <= '0;
                  state_ff <= S_FRAME;
               end
            end
            S_FRAME: begin
               // shift in at the top so byte 0 lands in bits 7:0 after eight slots
               data_ff <= {slot_byte, data_ff[63:8]};
               slot_ff <= slot_ff + 3'd1;
               if (slot_ff == 3'd7) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= data_ff;
                  rsp_len_ff   <= frame_len;
                  rsp_num_ff   <= 4'(frame_ff);
                  rsp_acc_ff   <= mbox_ff;
                  rsp_done_ff  <= mbox_ff && is_last;
                  if (mbox_ff) begin
                     if (is_last) begin
                        frame_ff       <= '0;
                        frame_base_ff  <= '0;
                        xfer_active_ff <= 1'b0;
                        xfer_cnt_ff    <= xfer_cnt_ff + 5'd1;
                     end else begin
                        frame_ff      <= frame_ff + FW'(1);
                        frame_base_ff <= rd_ptr_ff;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.frame_data     = rsp_data_ff;
   assign rsp.frame_length   = rsp_len_ff;
   assign rsp.frame_number   = rsp_num_ff;
   assign rsp.frame_accepted = rsp_acc_ff;
   assign rsp.transfer_done  = rsp_done_ff;

   // A completed transfer is only reported on an accepted frame
   `CMF_CHECK(a_done_needs_acc, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_acc_ff)
   // Frame index and base stay inside the transfer while it is active
   `CMF_CHECK(a_frame_range, clock, reset, xfer_active_ff,
              (frame_ff <= LAST_FRAME) && (frame_base_ff < P_W))
   // Hand-over with a free output register always presents a result
   `CMF_CHECK_NEXT(a_emit_loads, clock, reset, (state_ff == S_EMIT) && out_free, rsp_valid_ff)
   // Frame assembly and the copy only ever run inside an active transfer
   `CMF_CHECK(a_frame_active, clock, reset,
              (state_ff == S_FRAME) || (state_ff == S_COPY), xfer_active_ff)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the CAN multi-frame transfer framer.
// Depends on cmf_pkg and the cmf_req_if / cmf_rsp_if channel interfaces from the RTL.
`timescale 1ns / 100ps

module tb;
   import cmf_pkg::*;

   localparam int PAYLOAD_BYTES = 64;
   // frame 0 holds the CRC and five payload bytes, each later frame up to seven
   localparam int FRAME_COUNT   = 1 + (PAYLOAD_BYTES - FIRST_DATA + FRAME_DATA_MAX - 1)
                                      / FRAME_DATA_MAX;
   localparam int SETTLE_CYCLES = 120;      // room for a start tick plus one frame
   localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int PHASES        = 12;
   localparam int PRESSURE_PHASE = 4;

   // one emitted CAN frame as it leaves the block
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  length;
      logic [3:0]  number;
      logic        accepted;
      logic        done;
   } can_frame_t;

   typedef enum logic [1:0] {
      ROW_PREDICT,   // expectation from the frame predictor
      ROW_NONE,      // no frame may come of this item
      ROW_FRAME      // frame typed into the table
   } row_kind_t;

   typedef struct {
      cmd_type     cmd;
      logic [5:0]  index;
      logic [7:0]  value;
      logic        mbox_free;
      row_kind_t   kind;
      can_frame_t  frame;
   } script_row_t;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   cmf_req_if req_ch ();
   cmf_rsp_if rsp_ch ();

   can_multiframe_transfer_framer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Frame predictor: own copy of the framer's state and its period register
   // ---------------------------------------------------------------------------------
   logic [7:0]  staging_model  [PAYLOAD_BYTES];
   logic [7:0]  transmit_model [PAYLOAD_BYTES];
   logic [15:0] crc_model;
   logic [3:0]  frame_model;
   logic [4:0]  transfer_id_model;
   logic        active_model;
   logic [7:0]  tick_model;
   logic [7:0]  period_model;

   can_frame_t  pending_frames [$];

   // Advance the predictor by one accepted request; return 1 with the frame if one is due.
   function automatic bit predict_frame(input cmd_type cmd, input logic [5:0] index,
                                        input logic [7:0] value, input logic mbox_free,
                                        output can_frame_t fr);
      logic [7:0]  frame_bytes [8];
      logic [15:0] c;
      int unsigned f, off, n;
      fr = '0;
      if (cmd == CMD_WRITE) begin
         // staging only; an active CAN transfer works from its own snapshot
         staging_model[index] = value;
         return 1'b0;
      end
      tick_model = tick_model + 8'd1;           // wraps at 8 bits
      if (tick_model >= period_model) begin
         tick_model = 8'd0;
         if (!active_model) begin
            // snapshot the payload and take CRC-16-CCITT over it, MSB first
            transmit_model = staging_model;
            c = CRC_INIT;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               c = c ^ {transmit_model[i], 8'h00};
               for (int b = 0; b < 8; b++) begin
                  c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
               end
            end
            crc_model    = c;
            frame_model  = 4'd0;
            active_model = 1'b1;
         end
      end
      if (!active_model) begin
         return 1'b0;
      end
      f = frame_model;
      foreach (frame_bytes[b]) begin
         frame_bytes[b] = 8'h00;
      end
      if (f == 0) begin
         frame_bytes[0] = crc_model[7:0];
         frame_bytes[1] = crc_model[15:8];
         for (int i = 0; i < FIRST_DATA; i++) begin
            frame_bytes[2 + i] = transmit_model[i];
         end
         n = FRAME_DATA_MAX;                    // tail lands in byte 7
      end else begin
         off = FIRST_DATA + (f - 1) * FRAME_DATA_MAX;
         n   = (off < PAYLOAD_BYTES) ? PAYLOAD_BYTES - off : 0;
         if (n > FRAME_DATA_MAX) begin
            n = FRAME_DATA_MAX;
         end
         for (int i = 0; i < n; i++) begin
            frame_bytes[i] = transmit_model[off + i];
         end
      end
      // tail: start, end, toggle, transfer id
      frame_bytes[n] = {f == 0, f == FRAME_COUNT - 1, f[0], transfer_id_model};
      for (int b = 0; b < 8; b++) begin
         fr.data[8*b +: 8] = frame_bytes[b];
      end
      fr.length   = 4'(n + 1);
      fr.number   = 4'(f);
      fr.accepted = mbox_free;
      if (mbox_free) begin
         frame_model = frame_model + 4'd1;
         if (frame_model >= FRAME_COUNT) begin
            frame_model       = 4'd0;
            active_model      = 1'b0;
            transfer_id_model = transfer_id_model + 5'd1;
            fr.done           = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Directed script. Frames are typed in only where they are plain from the layout:
   // the final frame carries bytes 61..63 of the snapshot, and the write to byte 62
   // made mid-transfer must not show up in it.
   // ---------------------------------------------------------------------------------
   script_row_t script [17] = '{
      '{CMD_WRITE, 6'd0,  8'hFF, 1'b0, ROW_NONE,    '0},
      '{CMD_WRITE, 6'd63, 8'hA5, 1'b1, ROW_NONE,    '0},
      '{CMD_WRITE, 6'd61, 8'h5A, 1'b0, ROW_NONE,    '0},
      // first tick after reset reaches the period: start, frame 0 refused
      '{CMD_TICK,  6'd0,  8'h00, 1'b0, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_WRITE, 6'd62, 8'h3C, 1'b1, ROW_NONE,    '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd63, 8'hFF, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_PREDICT, '0},
      // last frame refused, then taken: end and toggle set, id 0
      '{CMD_TICK,  6'd0,  8'h00, 1'b0, ROW_FRAME,
        can_frame_t'{64'h0000_0000_60A5_005A, 4'd4, 4'd9, 1'b0, 1'b0}},
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_FRAME,
        can_frame_t'{64'h0000_0000_60A5_005A, 4'd4, 4'd9, 1'b1, 1'b1}},
      // tick with nothing in flight and the period not reached
      '{CMD_TICK,  6'd0,  8'h00, 1'b1, ROW_NONE,    '0}
   };

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------
   int send_idle_pct;
   int stall_pct;
   bit hold_armed;
   int items_sent;
   int ticks_sent;
   int periods_written;

   // Offer one request, hold it until the transfer, then book the expected frame.
   task automatic send_item(input cmd_type cmd, input logic [5:0] index,
                            input logic [7:0] value, input logic mbox_free,
                            input row_kind_t kind, input can_frame_t typed);
      can_frame_t predicted;
      bit         emits;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.byte_index   <= index;
      req_ch.byte_value   <= value;
      req_ch.mailbox_free <= mbox_free;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      emits = predict_frame(cmd, index, value, mbox_free, predicted);
      if (kind == ROW_FRAME) begin
         pending_frames.push_back(typed);
      end else if (kind == ROW_PREDICT && emits) begin
         pending_frames.push_back(predicted);
      end
      items_sent++;
      if (cmd == CMD_TICK) begin
         ticks_sent++;
      end
   endtask

   // Drop valid, drain every expected frame, then let trailing work finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [7:0] p);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      period_model  = p;
      periods_written++;
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: random back-pressure plus one long hold-off, counted here
   // ---------------------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   int mismatches;
   int frames_checked;
   int transfers_seen;
   int frames_refused;

   // Compare every accepted frame against the oldest expectation, field by field.
   always @(posedge clock) begin
      can_frame_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected frame: data %h number %0d", rsp_ch.frame_data,
                   rsp_ch.frame_number);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_ch.frame_data !== want.data) begin
               $error("frame_data: expected %h, got %h", want.data, rsp_ch.frame_data);
               mismatches++;
            end
            if (rsp_ch.frame_length !== want.length) begin
               $error("frame_length: expected %0d, got %0d", want.length,
                      rsp_ch.frame_length);
               mismatches++;
            end
            if (rsp_ch.frame_number !== want.number) begin
               $error("frame_number: expected %0d, got %0d", want.number,
                      rsp_ch.frame_number);
               mismatches++;
            end
            if (rsp_ch.frame_accepted !== want.accepted) begin
               $error("frame_accepted: expected %0b, got %0b", want.accepted,
                      rsp_ch.frame_accepted);
               mismatches++;
            end
            if (rsp_ch.transfer_done !== want.done) begin
               $error("transfer_done: expected %0b, got %0b", want.done,
                      rsp_ch.transfer_done);
               mismatches++;
            end
            frames_checked++;
            if (want.done) begin
               transfers_seen++;
            end
            if (!want.accepted) begin
               frames_refused++;
            end
         end
      end
   end

   // Watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("can_multiframe_transfer_framer_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   // period per phase: extremes 1 and 255, period zero twice, and a 255 -> 2 step
   // so that the period is lowered below a running counter
   int unsigned period_plan [PHASES] = '{1, 0, 255, 2, 10, 1, 25, 4, 0, 7, 3, 12};

   initial begin
      int unsigned per;
      int          n_items;
      int          tick_pct;

      // hold every input at a known value from time zero; the receiver process
      // drives its ready from the first edge, which falls inside reset
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 8'h00;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_WRITE;
      req_ch.byte_index   = 6'd0;
      req_ch.byte_value   = 8'h00;
      req_ch.mailbox_free = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_armed          = 1'b0;

      // predictor at its reset state; the counter starts one short of the reset period
      foreach (staging_model[i]) begin
         staging_model[i]  = 8'h00;
         transmit_model[i] = 8'h00;
      end
      crc_model         = 16'h0000;
      frame_model       = 4'd0;
      transfer_id_model = 5'd0;
      active_model      = 1'b0;
      tick_model        = PERIOD_RESET - 8'd1;
      period_model      = PERIOD_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the reset period and no idling
      foreach (script[r]) begin
         send_item(script[r].cmd, script[r].index, script[r].value, script[r].mbox_free,
                   script[r].kind, script[r].frame);
      end
      settle();

      // random phases: a new period each time, idling cycled through four patterns
      for (int ph = 0; ph < PHASES; ph++) begin
         per = (ph == 9) ? $urandom_range(1, 30) : period_plan[ph];
         write_period(8'(per));
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 67;
            end
            default: begin
               send_idle_pct = 34;
               stall_pct    <= 34;
            end
         endcase
         // hold the receiver off for a long stretch while requests keep coming
         if (ph == PRESSURE_PHASE) begin
            hold_armed <= 1'b1;
         end
         // the long period needs many ticks before its transfer starts
         n_items  = (per == 255) ? 420 : 115;
         tick_pct = (per == 255) ? 92 : 70;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < tick_pct) begin
               send_item(CMD_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 99) < 80, ROW_PREDICT, '0);
            end else begin
               send_item(CMD_WRITE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), ROW_PREDICT, '0);
            end
         end
         settle();
      end

      if (pending_frames.size() != 0) begin
         $error("%0d expected frames never arrived", pending_frames.size());
         mismatches++;
      end

      $display("Sent %0d requests (%0d ticks) over %0d period settings.",
               items_sent, ticks_sent, periods_written);
      $display("Checked %0d frames, %0d refused, %0d CAN transfers completed.",
               frames_checked, frames_refused, transfers_seen);
      if (mismatches == 0) begin
         $display("can_multiframe_transfer_framer_unit test passed");
      end else begin
         $display("can_multiframe_transfer_framer_unit test failed");
      end
      $finish;
   end

endmodule

FILE: can_multiframe_transfer_framer_unit.f
+incdir+rtl
rtl/cmf_pkg.sv
rtl/cmf_channels.sv
rtl/can_multiframe_transfer_framer_unit.sv
verif/tb.sv
